>>> hdl/psr_pkg.sv
// Shared types, constants and response-byte helpers for the projector
// status responder. No dependencies; every other file uses this package.
package psr_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 32;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [1:0]        cfg_idx_t;
  typedef logic [8:0]        pos_t;
  typedef logic [6:0]        resp_idx_t;
  typedef logic [4:0]        word_idx_t;
  typedef logic [2:0]        cnt_t;

  // Request / response framing
  localparam int    HDR_LEN         = 5;
  localparam int    HEAD_BYTES      = 3;
  localparam byte_t RESP_ID         = 8'h23;
  localparam byte_t CMD_COMMON      = 8'h8A;
  localparam byte_t CMD_TEMP        = 8'h99;
  localparam byte_t CMD_LAMP        = 8'h9B;
  localparam int    COMMON_LEN      = 98;
  localparam int    COMMON_LAMP_OFS = 94;
  localparam int    TEMP_LEN        = 5;
  localparam int    LAMP_LEN        = 7;

  // Configuration register indexes
  localparam cfg_idx_t REG_LAMP_USAGE    = 2'd0;
  localparam cfg_idx_t REG_INTAKE_TEMP   = 2'd1;
  localparam cfg_idx_t REG_EXHAUST_TEMP  = 2'd2;
  localparam cfg_idx_t REG_LAMP_CURRENT  = 2'd3;

  // Configuration reset values
  localparam word_t LAMP_USAGE_RST    = 32'd0;
  localparam word_t INTAKE_TEMP_RST   = 32'd25;
  localparam word_t EXHAUST_TEMP_RST  = 32'd35;
  localparam word_t LAMP_CURRENT_RST  = 32'd1000;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    word_t lamp_usage;
    word_t intake_temperature;
    word_t exhaust_temperature;
    word_t lamp_current_value;
  } cfg_t;

  // One framed request, as handed from the parser to the response generator
  typedef struct packed {
    byte_t                      cmd;
    logic [HEAD_BYTES-1:0][7:0] head;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEND
  } back_state_t;

  function automatic byte_t psr_payload_len(input byte_t cmd);
    byte_t len;
    case (cmd)
      CMD_COMMON: len = BYTE_W'(COMMON_LEN);
      CMD_TEMP:   len = BYTE_W'(TEMP_LEN);
      CMD_LAMP:   len = BYTE_W'(LAMP_LEN);
      default:    len = '0;
    endcase
    return len;
  endfunction

  // Number of response bytes including the trailing checksum
  function automatic resp_idx_t psr_resp_total(input byte_t cmd);
    byte_t len;
    len = psr_payload_len(cmd);
    return 7'(HDR_LEN) + len[6:0] + 7'd1;
  endfunction

  function automatic byte_t psr_le_byte(input word_t w, input logic [1:0] sel);
    return w[{sel, 3'b000} +: 8];
  endfunction

  // Response byte at a position, checksum position excluded
  function automatic byte_t psr_resp_byte(input job_t job, input cfg_t cfg,
                                          input resp_idx_t idx);
    byte_t     b;
    resp_idx_t p;
    b = '0;
    p = idx - 7'(HDR_LEN);
    if (idx < 7'(HDR_LEN)) begin
      case (idx[2:0])
        3'd0:    b = RESP_ID;
        3'd1:    b = job.cmd;
        3'd4:    b = psr_payload_len(job.cmd);
        default: b = '0;
      endcase
    end else begin
      case (job.cmd)
        CMD_COMMON: begin
          if (p >= 7'(COMMON_LAMP_OFS) && p < 7'(COMMON_LAMP_OFS + 4))
            b = psr_le_byte(cfg.lamp_usage, 2'(p - 7'(COMMON_LAMP_OFS)));
        end
        CMD_TEMP: begin
          if (p == 7'd0)
            b = job.head[0];
          else if (p < 7'd5)
            b = psr_le_byte((job.head[0] == '0) ? cfg.intake_temperature
                                                : cfg.exhaust_temperature,
                            2'(p - 7'd1));
        end
        CMD_LAMP: begin
          if (p < 7'(HEAD_BYTES))
            b = job.head[p[1:0]];
          else if (p < 7'(LAMP_LEN))
            b = psr_le_byte(cfg.lamp_current_value, 2'(p - 7'd3));
        end
        default: b = '0;
      endcase
    end
    return b;
  endfunction

endpackage

>>> hdl/psr_if.sv
// Channel interfaces of the projector status responder: request bytes,
// response words and configuration writes. Depends on psr_pkg.
interface psr_in_if;
  logic            valid;
  logic            ready;
  psr_pkg::byte_t  rx_byte;
  modport source (output valid, rx_byte, input ready);
  modport sink (input valid, rx_byte, output ready);
endinterface

interface psr_out_if;
  logic            valid;
  logic            ready;
  psr_pkg::word_t  tx_word;
  psr_pkg::cnt_t   byte_count;
  logic            last_word;
  modport source (output valid, tx_word, byte_count, last_word, input ready);
  modport sink (input valid, tx_word, byte_count, last_word, output ready);
endinterface

interface psr_cfg_if;
  logic              valid;
  logic              ready;
  psr_pkg::cfg_idx_t reg_index;
  psr_pkg::word_t    wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> hdl/psr_front.sv
// Request parser: tracks the byte position, captures command, length and the
// first payload bytes, and queues a job on the trailing byte. Uses psr_pkg.
module psr_front (
  input  logic            clk,
  input  logic            rst_n,
  psr_in_if.sink          in_if,
  output logic            push_valid,
  input  logic            push_ready,
  output psr_pkg::job_t   push_job
);
  import psr_pkg::*;

  pos_t  pos_r;
  byte_t cmd_r;
  byte_t len_r;
  byte_t head_r [HEAD_BYTES];

  logic  accept;
  logic  trailing;
  pos_t  head_idx;

  // Take a byte only when the job queue can absorb a completed request
  assign in_if.ready = push_ready;
  assign accept      = in_if.valid && push_ready;

  // The trailing byte follows the header and the announced payload
  assign trailing = (pos_r >= 9'(HDR_LEN)) && (pos_r >= 9'(HDR_LEN) + {1'b0, len_r});
  assign head_idx = pos_r - 9'(HDR_LEN);

  assign push_valid = in_if.valid && trailing;

  // Build the job, zeroing head bytes beyond the request payload
  always_comb begin
    push_job.cmd = cmd_r;
    for (int i = 0; i < HEAD_BYTES; i++) begin
      push_job.head[i] = (BYTE_W'(i) < len_r) ? head_r[i] : '0;
    end
  end

  // Advance the byte position and capture header and payload bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cmd_r <= '0;
      len_r <= '0;
      for (int i = 0; i < HEAD_BYTES; i++) head_r[i] <= '0;
    end else if (accept) begin
      if (pos_r == 9'd1) cmd_r <= in_if.rx_byte;
      if (pos_r == 9'd4) len_r <= in_if.rx_byte;
      if (trailing) begin
        pos_r <= '0;
      end else begin
        if (pos_r >= 9'(HDR_LEN) && head_idx < 9'(HEAD_BYTES))
          head_r[head_idx[1:0]] <= in_if.rx_byte;
        pos_r <= pos_r + 9'd1;
      end
    end
  end

endmodule

>>> hdl/psr_queue.sv
// Small job queue between the request parser and the response generator.
// Register storage, one read port at the read pointer. Uses psr_pkg.
module psr_queue #(
  parameter int unsigned DEPTH = psr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  psr_pkg::job_t   push_job,
  output logic            pop_valid,
  input  logic            pop_ready,
  output psr_pkg::job_t   pop_job
);
  import psr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Hold job entries
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)
        count_r <= count_r + 1'b1;
      else if (do_pop && !do_push)
        count_r <= count_r - 1'b1;
    end
  end

endmodule

>>> hdl/psr_back.sv
// Response generator: takes one job at a time, packs the response four bytes
// per word with a running checksum, into an output register. Uses psr_pkg.
module psr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  psr_pkg::job_t   pop_job,
  input  psr_pkg::cfg_t   cfg,
  psr_out_if.source       out_if
);
  import psr_pkg::*;

  back_state_t state_r, state_nxt;
  job_t        job_r, job_nxt;
  word_idx_t   widx_r, widx_nxt;
  byte_t       sum_r, sum_nxt;

  logic        out_valid_r;
  word_t       word_r;
  cnt_t        cnt_r;
  logic        last_r;

  resp_idx_t   total;
  resp_idx_t   base;
  resp_idx_t   rem;
  cnt_t        cnt;
  logic        last;
  word_t       word;
  byte_t       lane_sum;
  logic        slot_free;
  logic        emit;

  assign out_if.valid      = out_valid_r;
  assign out_if.tx_word    = word_r;
  assign out_if.byte_count = cnt_r;
  assign out_if.last_word  = last_r;

  assign slot_free = !out_valid_r || out_if.ready;

  // Lay out the current word; the checksum lane sums every earlier byte
  always_comb begin
    resp_idx_t idx;
    byte_t     b;
    total    = psr_resp_total(job_r.cmd);
    base     = {widx_r, 2'b00};
    rem      = total - base;
    cnt      = (rem >= 7'd4) ? 3'd4 : rem[2:0];
    last     = (rem <= 7'd4);
    lane_sum = '0;
    word     = '0;
    for (int j = 0; j < 4; j++) begin
      idx = base + 7'(j);
      b   = psr_resp_byte(job_r, cfg, idx);
      if (idx == total - 7'd1) b = sum_r + lane_sum;
      if (3'(j) >= cnt) b = '0;
      lane_sum = lane_sum + b;
      word[j*8 +: 8] = b;
    end
  end

  // Next state: load a job, then emit one word each time the slot frees
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    widx_nxt  = widx_r;
    sum_nxt   = sum_r;
    pop_ready = 1'b0;
    emit      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          job_nxt   = pop_job;
          widx_nxt  = '0;
          sum_nxt   = '0;
          state_nxt = BK_SEND;
        end
      end
      BK_SEND: begin
        if (slot_free) begin
          emit     = 1'b1;
          widx_nxt = widx_r + 5'd1;
          sum_nxt  = sum_r + lane_sum;
          if (last) state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Job and packing progress
  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    widx_r <= widx_nxt;
    sum_r  <= sum_nxt;
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      word_r <= word;
      cnt_r  <= cnt;
      last_r <= last;
    end
  end

endmodule

>>> hdl/projector_status_responder.sv
// Projector status responder top level: configuration registers, request
// parser, job queue and response generator. Uses psr_pkg and psr_if.
// With the generator idle, the first response word is valid once the trailing request byte
// has passed through the queue entry, the generator's job register and the output register;
// further words follow one per cycle while out is ready. One request byte per cycle is taken
// while the job queue has room; a response of 2 to 26 words holds the generator until sent.
// Reset (synchronous, rst_n low): parser at byte 0, queue empty, output idle,
// registers at lamp usage 0, intake 25, exhaust 35, lamp current 1000.
module projector_status_responder #(
  parameter int unsigned QUEUE_DEPTH = psr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  psr_in_if.sink     in_if,
  psr_out_if.source  out_if,
  psr_cfg_if.sink    cfg_if
);
  import psr_pkg::*;

  cfg_t cfg_r;
  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  // Configuration writes are always taken
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lamp_usage          <= LAMP_USAGE_RST;
      cfg_r.intake_temperature  <= INTAKE_TEMP_RST;
      cfg_r.exhaust_temperature <= EXHAUST_TEMP_RST;
      cfg_r.lamp_current_value  <= LAMP_CURRENT_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.reg_index)
        REG_LAMP_USAGE:   cfg_r.lamp_usage          <= cfg_if.wdata;
        REG_INTAKE_TEMP:  cfg_r.intake_temperature  <= cfg_if.wdata;
        REG_EXHAUST_TEMP: cfg_r.exhaust_temperature <= cfg_if.wdata;
        REG_LAMP_CURRENT: cfg_r.lamp_current_value  <= cfg_if.wdata;
        default: ;
      endcase
    end
  end

  psr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  psr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  psr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .cfg       (cfg_r),
    .out_if    (out_if)
  );

  // Every word carries one to four bytes
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.byte_count >= 3'd1 && out_if.byte_count <= 3'd4))
    else $error("byte_count out of range");

  // Only the final word of a response may be partial
  a_full_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.last_word) |-> (out_if.byte_count == 3'd4))
    else $error("partial word before end of response");

  // Reset empties the output register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("output valid after reset");

endmodule
